// ===== src/blowfish_cipher_with_chained_digest_unit_macros.svh =====
// Assertion macros used by the checker file of the cipher block.
`ifndef BLOWFISH_CIPHER_WITH_CHAINED_DIGEST_UNIT_MACROS_SVH
`define BLOWFISH_CIPHER_WITH_CHAINED_DIGEST_UNIT_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is held.
`define BCD_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define BCD_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/bcd_pkg.sv =====
// Shared types, codes and a helper function of the cipher block.
package bcd_pkg;

    localparam int ROUNDS_DEFAULT = 16;

    localparam logic [31:0] CHAIN_INIT_FIRST  = 32'h0102_0304;
    localparam logic [31:0] CHAIN_INIT_SECOND = 32'h0506_0708;

    typedef enum logic [2:0] {
        OP_LOAD_KEY  = 3'd0,
        OP_LOAD_SBOX = 3'd1,
        OP_ENCRYPT   = 3'd2,
        OP_DECRYPT   = 3'd3,
        OP_ABSORB    = 3'd4,
        OP_FINISH    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        KIND_ENC    = 2'd0,
        KIND_DEC    = 2'd1,
        KIND_DIGEST = 2'd2
    } kind_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RND_A = 6'b000010,
        ST_RND_B = 6'b000100,
        ST_FIN_R = 6'b001000,
        ST_FIN_L = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // Write request into the substitution box banks.
    typedef struct packed {
        logic        en;
        logic [1:0]  box;
        logic [7:0]  idx;
        logic [31:0] word;
    } sbox_wr_t;

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ===== src/bcd_sbox.sv =====
// Four banked substitution box memories and the round function on their outputs.
module bcd_sbox (
    input  logic              aclk,
    input  bcd_pkg::sbox_wr_t wr_req,
    input  logic [31:0]       rd_word,
    output logic [31:0]       f_out
);

    logic [31:0] bank [4][256];
    logic [31:0] q_reg [4];

    always_ff @(posedge aclk) begin
        for (int b = 0; b < 4; b++) begin
            if (wr_req.en && (wr_req.box == 2'(b))) begin
                bank[b][wr_req.idx] <= wr_req.word;
            end
            // box 0 takes the top byte, box 3 the bottom one
            q_reg[b] <= bank[b][rd_word[8*(3-b) +: 8]];
        end
    end

    assign f_out = q_reg[3] + (q_reg[2] ^ (q_reg[1] + q_reg[0]));

endmodule

// ===== src/blowfish_cipher_with_chained_digest_unit.sv =====
// Blowfish block cipher with a chained digest, table loading and a stream interface.
// Works on one request at a time. Subkey and sbox loads give no result. Encrypt,
// decrypt and absorb fetch the first subkey when the request is taken, then run
// ROUNDS rounds (sbox bank read, then mix) and the final whitening of the right half,
// then the left half, through the registered subkey port; an encrypt or decrypt holds
// the input until its result is handed to the output register, and an absorb, which
// has no result, until the chain is updated. Finish skips the rounds and goes to the
// hand-off of its digest. A result waiting in the output register stalls the input
// only once the next result is ready to leave. Subkey and sbox tables have no reset and
// must be loaded before use; a load of a subkey beyond index ROUNDS+1 is dropped, and
// op codes 6 and 7 are ignored.
module blowfish_cipher_with_chained_digest_unit #(
    parameter int ROUNDS = bcd_pkg::ROUNDS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // table_index[7:0], table_word[39:8], left_half[71:40], right_half[103:72],
    // element[167:104]
    input  logic [167:0] s_tdata,
    // op[2:0], box_select[4:3]
    input  logic [4:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // left_out[31:0], right_out[63:32], digest[127:64]
    output logic [127:0] m_tdata,
    // kind[1:0]
    output logic [1:0]   m_tuser
);

    localparam int NKEYS = ROUNDS + 2;
    localparam int KW    = $clog2(NKEYS);
    localparam int RW    = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    bcd_pkg::op_t   s_op;
    logic [1:0]     s_box;
    logic [7:0]     s_index;
    logic [31:0]    s_word;
    logic [31:0]    s_left;
    logic [31:0]    s_right;
    logic [63:0]    s_element;
    logic           accept;

    assign s_op      = bcd_pkg::op_t'(s_tuser[2:0]);
    assign s_box     = s_tuser[4:3];
    assign s_index   = s_tdata[7:0];
    assign s_word    = s_tdata[39:8];
    assign s_left    = s_tdata[71:40];
    assign s_right   = s_tdata[103:72];
    assign s_element = s_tdata[167:104];

    bcd_pkg::state_t state_reg, state_next;
    bcd_pkg::op_t    mode_reg, mode_next;
    logic [RW-1:0]   rnd_reg, rnd_next;
    logic [31:0]     a_reg, a_next;
    logic [31:0]     b_reg, b_next;
    logic [31:0]     t_reg, t_next;
    logic [31:0]     chain_first_reg, chain_first_next;
    logic [31:0]     chain_second_reg, chain_second_next;
    bcd_pkg::kind_t  pend_kind_reg, pend_kind_next;
    logic [31:0]     pend_left_reg, pend_left_next;
    logic [31:0]     pend_right_reg, pend_right_next;
    logic [63:0]     pend_digest_reg, pend_digest_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [1:0]      m_tuser_reg, m_tuser_next;
    logic [127:0]    m_tdata_reg, m_tdata_next;

    logic [31:0]     pkey_mem [NKEYS];
    logic [31:0]     pkey_q_reg;
    logic [KW-1:0]   pkey_raddr;
    logic            pkey_we;

    bcd_pkg::sbox_wr_t sbox_wr;
    logic [31:0]       sbox_rd_word;
    logic [31:0]       f_val;
    logic              is_dec;
    logic [RW-1:0]     rnd_inc;
    logic [31:0]       fin_left;

    assign s_tready = (state_reg == bcd_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_dec   = (mode_reg == bcd_pkg::OP_DECRYPT);
    assign rnd_inc  = rnd_reg + RW'(1);
    assign fin_left = pkey_q_reg ^ b_reg;

    // Subkey memory: written on a load request, read through a register ahead of its use.
    assign pkey_we = accept && (s_op == bcd_pkg::OP_LOAD_KEY) && (s_index < 8'(NKEYS));

    always_ff @(posedge aclk) begin
        if (pkey_we) begin
            pkey_mem[s_index[KW-1:0]] <= s_word;
        end
        pkey_q_reg <= pkey_mem[pkey_raddr];
    end

    always_comb begin
        pkey_raddr = '0;
        unique case (state_reg)
            bcd_pkg::ST_IDLE: begin
                pkey_raddr = (s_op == bcd_pkg::OP_DECRYPT) ? KW'(ROUNDS + 1) : '0;
            end
            bcd_pkg::ST_RND_B: begin
                if (rnd_reg == RW'(ROUNDS - 1)) begin
                    pkey_raddr = is_dec ? KW'(1) : KW'(ROUNDS);
                end else begin
                    pkey_raddr = is_dec ? (KW'(ROUNDS + 1) - KW'(rnd_inc)) : KW'(rnd_inc);
                end
            end
            bcd_pkg::ST_FIN_R: begin
                pkey_raddr = is_dec ? '0 : KW'(ROUNDS + 1);
            end
            default: begin
                pkey_raddr = '0;
            end
        endcase
    end

    assign sbox_wr.en   = accept && (s_op == bcd_pkg::OP_LOAD_SBOX);
    assign sbox_wr.box  = s_box;
    assign sbox_wr.idx  = s_index;
    assign sbox_wr.word = s_word;

    // Round input: subkey mixed into the left half, used as the sbox address.
    assign sbox_rd_word = pkey_q_reg ^ a_reg;

    bcd_sbox u_sbox (
        .aclk    (aclk),
        .wr_req  (sbox_wr),
        .rd_word (sbox_rd_word),
        .f_out   (f_val)
    );

    always_comb begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        rnd_next          = rnd_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        t_next            = t_reg;
        chain_first_next  = chain_first_reg;
        chain_second_next = chain_second_reg;
        pend_kind_next    = pend_kind_reg;
        pend_left_next    = pend_left_reg;
        pend_right_next   = pend_right_reg;
        pend_digest_next  = pend_digest_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tuser_next      = m_tuser_reg;
        m_tdata_next      = m_tdata_reg;

        unique case (state_reg)
            bcd_pkg::ST_IDLE: begin
                if (accept) begin
                    mode_next = s_op;
                    rnd_next  = '0;
                    unique case (s_op)
                        bcd_pkg::OP_ENCRYPT, bcd_pkg::OP_DECRYPT: begin
                            a_next     = s_left;
                            b_next     = s_right;
                            state_next = bcd_pkg::ST_RND_A;
                        end
                        bcd_pkg::OP_ABSORB: begin
                            a_next = chain_first_reg ^ bcd_pkg::swap_bytes(s_element[31:0]);
                            b_next = chain_second_reg ^ bcd_pkg::swap_bytes(s_element[63:32]);
                            state_next = bcd_pkg::ST_RND_A;
                        end
                        bcd_pkg::OP_FINISH: begin
                            pend_kind_next   = bcd_pkg::KIND_DIGEST;
                            pend_left_next   = '0;
                            pend_right_next  = '0;
                            pend_digest_next = {bcd_pkg::swap_bytes(chain_second_reg),
                                                bcd_pkg::swap_bytes(chain_first_reg)};
                            chain_first_next  = bcd_pkg::CHAIN_INIT_FIRST;
                            chain_second_next = bcd_pkg::CHAIN_INIT_SECOND;
                            state_next = bcd_pkg::ST_DONE;
                        end
                        default: begin
                            // loads are taken by the memories; unused codes drop
                            state_next = bcd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bcd_pkg::ST_RND_A: begin
                t_next     = sbox_rd_word;
                state_next = bcd_pkg::ST_RND_B;
            end
            bcd_pkg::ST_RND_B: begin
                a_next = b_reg ^ f_val;
                b_next = t_reg;
                if (rnd_reg == RW'(ROUNDS - 1)) begin
                    state_next = bcd_pkg::ST_FIN_R;
                end else begin
                    rnd_next   = rnd_inc;
                    state_next = bcd_pkg::ST_RND_A;
                end
            end
            bcd_pkg::ST_FIN_R: begin
                t_next     = pkey_q_reg ^ a_reg;
                state_next = bcd_pkg::ST_FIN_L;
            end
            bcd_pkg::ST_FIN_L: begin
                if (mode_reg == bcd_pkg::OP_ABSORB) begin
                    chain_first_next  = fin_left;
                    chain_second_next = t_reg;
                    state_next        = bcd_pkg::ST_IDLE;
                end else begin
                    pend_kind_next   = is_dec ? bcd_pkg::KIND_DEC : bcd_pkg::KIND_ENC;
                    pend_left_next   = fin_left;
                    pend_right_next  = t_reg;
                    pend_digest_next = '0;
                    state_next       = bcd_pkg::ST_DONE;
                end
            end
            bcd_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = pend_kind_reg;
                    m_tdata_next  = {pend_digest_reg, pend_right_reg, pend_left_reg};
                    state_next    = bcd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= bcd_pkg::ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            chain_first_reg  <= bcd_pkg::CHAIN_INIT_FIRST;
            chain_second_reg <= bcd_pkg::CHAIN_INIT_SECOND;
        end else begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            chain_first_reg  <= chain_first_next;
            chain_second_reg <= chain_second_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg        <= mode_next;
        rnd_reg         <= rnd_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        t_reg           <= t_next;
        pend_kind_reg   <= pend_kind_next;
        pend_left_reg   <= pend_left_next;
        pend_right_reg  <= pend_right_next;
        pend_digest_reg <= pend_digest_next;
        m_tuser_reg     <= m_tuser_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/bcd_checker.sv =====
// Port-level checks of the cipher block and their binding to the top level.
`include "blowfish_cipher_with_chained_digest_unit_macros.svh"

module bcd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [4:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser
);

    `BCD_ASSERT_ALL(a_reset_clears, aclk, !aresetn |=> (!m_tvalid && s_tready), "reset must leave the output empty and the input ready")

    `BCD_ASSERT_RST(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

    `BCD_ASSERT_RST(a_busy_after_work, aclk, aresetn, (s_tvalid && s_tready && (s_tuser[2:0] == bcd_pkg::OP_ENCRYPT || s_tuser[2:0] == bcd_pkg::OP_DECRYPT || s_tuser[2:0] == bcd_pkg::OP_ABSORB || s_tuser[2:0] == bcd_pkg::OP_FINISH)) |=> !s_tready, "block took a second request while working")

    `BCD_ASSERT_RST(a_field_zeroes, aclk, aresetn, m_tvalid |-> ((m_tuser == bcd_pkg::KIND_DIGEST) ? (m_tdata[63:0] == 64'd0) : (m_tdata[127:64] == 64'd0)), "unused result fields not zero")

endmodule

bind blowfish_cipher_with_chained_digest_unit bcd_checker u_bcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/tb_blowfish_cipher_with_chained_digest_unit.sv =====
// Stream-level test of the Blowfish cipher and chained digest block against a local predictor.
`timescale 1ns / 100ps

module tb_blowfish_cipher_with_chained_digest_unit;
    import bcd_pkg::*;

    localparam int NR = ROUNDS_DEFAULT;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int RANDOM_REQUESTS = 420;

    typedef struct packed {
        logic [31:0] l;
        logic [31:0] r;
    } block_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] left_out;
        logic [31:0] right_out;
        logic [63:0] digest;
    } cipher_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic [4:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    // Predictor state
    logic [31:0] subkey_words [NR + 2];
    logic [31:0] sbox_words [4][256];
    logic [31:0] chain_lo = CHAIN_INIT_FIRST;
    logic [31:0] chain_hi = CHAIN_INIT_SECOND;

    cipher_result_t pending_results [$];
    int fault_count = 0;
    int effective_requests = 0;
    bit steady = 1'b0;

    always #5 aclk = ~aclk;

    blowfish_cipher_with_chained_digest_unit #(
        .ROUNDS(NR)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic logic [63:0] rand_wide();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] byte_reverse(input logic [31:0] v);
        logic [31:0] flipped;
        flipped = {<<8{v}};
        return flipped;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] v);
        return sbox_words[3][v[7:0]] +
               (sbox_words[2][v[15:8]] ^ (sbox_words[1][v[23:16]] + sbox_words[0][v[31:24]]));
    endfunction

    function automatic block_t encipher(input block_t blk);
        logic [31:0] a, b, t;
        block_t res;
        a = blk.l;
        b = blk.r;
        for (int i = 0; i < NR; i++) begin
            t = subkey_words[i] ^ a;
            a = b ^ feistel(t);
            b = t;
        end
        res.r = subkey_words[NR] ^ a;
        res.l = subkey_words[NR + 1] ^ b;
        return res;
    endfunction

    function automatic block_t decipher(input block_t blk);
        logic [31:0] a, b, t;
        block_t res;
        a = blk.l;
        b = blk.r;
        for (int i = NR + 1; i > 1; i--) begin
            t = subkey_words[i] ^ a;
            a = b ^ feistel(t);
            b = t;
        end
        res.r = subkey_words[1] ^ a;
        res.l = subkey_words[0] ^ b;
        return res;
    endfunction

    // Advance the predictor by one accepted request.
    function automatic void predict_request(input logic [2:0] op, input logic [1:0] box,
                                            input logic [7:0] idx, input logic [31:0] word,
                                            input block_t blk, input logic [63:0] elem);
        cipher_result_t res;
        block_t c;
        res.left_out  = '0;
        res.right_out = '0;
        res.digest    = '0;
        case (op)
            OP_LOAD_KEY: begin
                if (idx < NR + 2) begin
                    subkey_words[idx] = word;
                    effective_requests++;
                end
            end
            OP_LOAD_SBOX: begin
                sbox_words[box][idx] = word;
                effective_requests++;
            end
            OP_ENCRYPT, OP_DECRYPT: begin
                c = (op == OP_ENCRYPT) ? encipher(blk) : decipher(blk);
                res.kind      = (op == OP_ENCRYPT) ? KIND_ENC : KIND_DEC;
                res.left_out  = c.l;
                res.right_out = c.r;
                pending_results.push_back(res);
                effective_requests++;
            end
            OP_ABSORB: begin
                c.l = chain_lo ^ byte_reverse(elem[31:0]);
                c.r = chain_hi ^ byte_reverse(elem[63:32]);
                c = encipher(c);
                chain_lo = c.l;
                chain_hi = c.r;
                effective_requests++;
            end
            OP_FINISH: begin
                res.kind   = KIND_DIGEST;
                res.digest = {byte_reverse(chain_hi), byte_reverse(chain_lo)};
                pending_results.push_back(res);
                chain_lo = CHAIN_INIT_FIRST;
                chain_hi = CHAIN_INIT_SECOND;
                effective_requests++;
            end
            default: ;
        endcase
    endfunction

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch in %s: expected %h, got %h", what, want, got);
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [1:0] box,
                                input logic [7:0] idx, input logic [31:0] word,
                                input block_t blk, input logic [63:0] elem);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {box, op};
        s_tdata  <= {elem, blk.r, blk.l, word, idx};
        do @(posedge aclk); while (!s_tready);
        predict_request(op, box, idx, word, blk, elem);
    endtask

    task automatic send_block(input logic [2:0] op, input block_t blk);
        send_request(op, 2'($urandom), 8'($urandom), $urandom, blk, rand_wide());
    endtask

    task automatic send_element(input logic [2:0] op, input logic [63:0] elem);
        send_request(op, 2'($urandom), 8'($urandom), $urandom, rand_wide(), elem);
    endtask

    task automatic send_table(input logic [2:0] op, input logic [1:0] box,
                              input logic [7:0] idx, input logic [31:0] word);
        send_request(op, box, idx, word, rand_wide(), rand_wide());
    endtask

    // Finish straight after reset: digest of the starting constants.
    task automatic test_digest_from_reset();
        send_element(OP_FINISH, rand_wide());
    endtask

    task automatic test_table_load();
        for (int i = 0; i < NR + 2; i++)
            send_table(OP_LOAD_KEY, 2'($urandom), 8'(i), (i == 0) ? 32'h0 : $urandom);
        for (int b = 0; b < 4; b++) begin
            for (int e = 0; e < 256; e++) begin
                if (e == 0)
                    send_table(OP_LOAD_SBOX, 2'(b), 8'(e), 32'h0);
                else if (e == 255)
                    send_table(OP_LOAD_SBOX, 2'(b), 8'(e), 32'hffff_ffff);
                else
                    send_table(OP_LOAD_SBOX, 2'(b), 8'(e), $urandom);
            end
        end
    endtask

    // Out-of-range subkey loads and spare op codes must leave everything alone.
    task automatic test_ignored_requests();
        send_table(OP_LOAD_KEY, 2'd0, 8'(NR + 2), $urandom);
        send_table(OP_LOAD_KEY, 2'd3, 8'hff, $urandom);
        send_element(OP_SPARE_6, rand_wide());
        send_element(OP_SPARE_7, rand_wide());
        send_block(OP_ENCRYPT, rand_wide());
    endtask

    task automatic test_block_extremes();
        block_t blk;
        blk = rand_wide();
        send_block(OP_ENCRYPT, '0);
        send_block(OP_ENCRYPT, '1);
        send_block(OP_DECRYPT, '0);
        send_block(OP_DECRYPT, '1);
        send_block(OP_ENCRYPT, blk);
        send_block(OP_DECRYPT, encipher(blk));
    endtask

    // Cipher requests in mid-chain must not disturb the digest.
    task automatic test_digest_chain();
        send_element(OP_ABSORB, '0);
        send_element(OP_ABSORB, '1);
        send_block(OP_ENCRYPT, rand_wide());
        send_block(OP_DECRYPT, rand_wide());
        send_element(OP_ABSORB, rand_wide());
        send_element(OP_FINISH, rand_wide());
        send_element(OP_FINISH, rand_wide());
    endtask

    task automatic test_random_traffic();
        int start, pick;
        start = effective_requests;
        while (effective_requests - start < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 49) == 0)
                steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_block(OP_ENCRYPT, rand_wide());
            end else if (pick < 50) begin
                send_block(OP_DECRYPT, rand_wide());
            end else if (pick < 75) begin
                repeat ($urandom_range(0, 5)) send_element(OP_ABSORB, rand_wide());
                send_element(OP_FINISH, rand_wide());
            end else if (pick < 82) begin
                send_table(OP_LOAD_SBOX, 2'($urandom), 8'($urandom), $urandom);
            end else if (pick < 86) begin
                send_table(OP_LOAD_KEY, 2'($urandom), 8'($urandom_range(0, NR + 1)),
                           $urandom);
            end else if (pick < 90) begin
                send_table(OP_LOAD_KEY, 2'($urandom), 8'($urandom_range(NR + 2, 255)),
                           $urandom);
            end else if (pick < 94) begin
                send_element(3'($urandom_range(6, 7)), rand_wide());
            end else begin
                // absorb left hanging until some later finish
                send_element(OP_ABSORB, rand_wide());
            end
        end
        steady = 1'b0;
    endtask

    // Result side: unless the traffic is steady, stall for a random number of cycles before each result.
    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        cipher_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing pending", '0, m_tdata[127:64]);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    flag_mismatch("kind", 64'(want.kind), 64'(m_tuser));
                if (m_tdata[31:0] !== want.left_out)
                    flag_mismatch("left_out", 64'(want.left_out), 64'(m_tdata[31:0]));
                if (m_tdata[63:32] !== want.right_out)
                    flag_mismatch("right_out", 64'(want.right_out), 64'(m_tdata[63:32]));
                if (m_tdata[127:64] !== want.digest)
                    flag_mismatch("digest", want.digest, m_tdata[127:64]);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int waited;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_digest_from_reset();
        test_table_load();
        test_ignored_requests();
        test_block_extremes();
        test_digest_chain();
        test_random_traffic();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (60) @(posedge aclk);
        if (pending_results.size() != 0)
            flag_mismatch("results never delivered", 64'(pending_results.size()), '0);

        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
